### rtl/sdf_pkg.sv
// ----------------------------------------------------------------------------
// Sweeping delay flanger package
// Shared widths, arithmetic constants and types for the flanger delay line.
// ----------------------------------------------------------------------------
package sdf_pkg;

  // Default sizes, handed to the top level as parameter defaults.
  localparam int MAX_DELAY_DEF   = 1024;
  localparam int SAMPLE_BITS_DEF = 24;

  // Delay length register.
  localparam int                CFG_W     = 11;
  localparam logic [CFG_W-1:0]  LEN_RESET = 11'd960;
  localparam int                MIN_LEN   = 2;

  // Field widths and fixed-point formats.
  localparam int RATE_W     = 16;
  localparam int DEPTH_W    = 16;
  localparam int DEPTH_FRAC = 12;
  localparam int ROUND_HALF = 1 << (DEPTH_FRAC - 1);
  localparam int FRAC_W     = 16;
  localparam int STEP_W     = 19;

  // Step generation: step = 65536 + round(rate * 128 / 25).
  // With y = 128 * rate + STEP_Y_BIAS (always positive), the rounded quotient
  // is floor(y / 25) - 200000, and floor(y / 25) is taken by a reciprocal
  // multiply that is exact for every y below 2^STEP_Y_W.
  localparam int RATE_SHIFT  = 7;
  localparam int STEP_Y_W    = 24;
  localparam int STEP_Y_BIAS = 5000012;
  localparam int RECIP_W     = 25;
  localparam int RECIP_M     = 21474837;
  localparam int RECIP_SH    = 29;
  localparam int STEP_OFFSET = 134464;

  // Position reduction unit state.
  typedef enum logic {
    NORM_IDLE,
    NORM_RUN
  } norm_state_t;

  // How the delayed sample of an item is to be taken.
  typedef struct packed {
    logic fwd;     // read slot is the slot written by the same item
    logic stored;  // read slot has been written since reset
  } rd_info_t;

endpackage

### rtl/sdf_if.sv
// ----------------------------------------------------------------------------
// Sweeping delay flanger channel interfaces
// Valid/ready channels for the input items and the result items.
// ----------------------------------------------------------------------------
interface sdf_in_if import sdf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic signed [RATE_W-1:0]      sweep_rate;
  logic signed [DEPTH_W-1:0]     wet_depth;

  modport source (output valid, output sample_in, output sweep_rate, output wet_depth,
                  input ready);
  modport sink   (input valid, input sample_in, input sweep_rate, input wet_depth,
                  output ready);
endinterface

interface sdf_out_if import sdf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

### rtl/sweeping_delay_flanger.sv
// ----------------------------------------------------------------------------
// Sweeping delay flanger
// Circular delay line with a swept fractional read position and wet mix.
// ----------------------------------------------------------------------------
// Each transaction on in_ch carries one dry sample, a sweep rate and a wet
// depth; each one yields exactly one transaction on out_ch, in order.
// The sample is written into the delay memory, the slot under the integer
// part of the read position is read (a read of the slot just written returns
// the new sample), the position moves on by 1 + rate * 0.02 samples and the
// output is the dry sample plus the delayed sample times the depth,
// saturated to the sample width.
// The block takes one transaction per clock while out_ch does not stall and
// no reduction runs. A result on out_ch passes the input register, step
// generation, memory access and position update, depth product and output
// register. A stall on out_ch freezes the whole pipeline, and in_ch.ready
// follows out_ch.ready while the output register is full.
// cfg_we writes the delay length. After each write, a reduction unit brings
// the read position back into the new length, one quotient bit per cycle, and
// in_ch.ready is low while it runs.
// Reset is synchronous. It empties the pipeline and sets the length to 960.
// The memory is not swept: slots not yet written since reset read as zero.
// ----------------------------------------------------------------------------
module sweeping_delay_flanger import sdf_pkg::*; #(
  parameter int MAX_DELAY   = MAX_DELAY_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  sdf_in_if.sink           in_ch,
  sdf_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_DELAY);
  localparam int LW = $clog2(MAX_DELAY + 1);

  // Control state.
  logic             v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic [CFG_W-1:0] cfg_len_r;

  // Stage payloads.
  logic signed [SAMPLE_BITS-1:0] sample1_r, sample2_r, sample3_r;
  logic signed [RATE_W-1:0]      rate1_r;
  logic signed [DEPTH_W-1:0]     depth1_r, depth2_r, depth3_r;
  logic signed [STEP_W-1:0]      step2_r;
  rd_info_t                      rd3_r;
  logic signed [SAMPLE_BITS-1:0] sample_out_r;

  logic                          advance;
  logic                          busy;
  logic                          item_en;
  logic [LW-1:0]                 eff_len;
  logic signed [STEP_W-1:0]      step1;
  logic [AW-1:0]                 waddr, raddr;
  rd_info_t                      rd_info;
  logic [SAMPLE_BITS-1:0]        rdata;
  logic signed [SAMPLE_BITS-1:0] delayed3;
  logic signed [SAMPLE_BITS-1:0] mix;

  // The whole pipeline moves whenever the output register can take a result.
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = advance && !busy;
  assign item_en     = advance && v2_r;

  // Lengths below two act as two, lengths above the memory as the memory.
  always_comb begin
    if (cfg_len_r < CFG_W'(MIN_LEN)) begin
      eff_len = LW'(MIN_LEN);
    end else if (32'(cfg_len_r) > 32'(MAX_DELAY)) begin
      eff_len = LW'(MAX_DELAY);
    end else begin
      eff_len = LW'(cfg_len_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_len_r   <= LEN_RESET;
    end else begin
      if (advance) begin
        v1_r        <= in_ch.valid && in_ch.ready;
        v2_r        <= v1_r;
        v3_r        <= v2_r;
        v4_r        <= v3_r;
        out_valid_r <= v4_r;
      end
      if (cfg_we) begin
        cfg_len_r <= cfg_wdata;
      end
    end
  end

  // Payload registers carry no reset; the valid chain qualifies them.
  always_ff @(posedge clk) begin
    if (advance) begin
      sample1_r    <= in_ch.sample_in;
      rate1_r      <= in_ch.sweep_rate;
      depth1_r     <= in_ch.wet_depth;
      sample2_r    <= sample1_r;
      depth2_r     <= depth1_r;
      step2_r      <= step1;
      sample3_r    <= sample2_r;
      depth3_r     <= depth2_r;
      rd3_r        <= rd_info;
      sample_out_r <= mix;
    end
  end

  sdf_step_gen u_step_gen (
    .sweep_rate (rate1_r),
    .step       (step1)
  );

  sdf_position #(
    .MAX_DELAY (MAX_DELAY)
  ) u_position (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_en (item_en),
    .cfg_we  (cfg_we),
    .eff_len (eff_len),
    .step    (step2_r),
    .waddr   (waddr),
    .raddr   (raddr),
    .rd_info (rd_info),
    .busy    (busy)
  );

  sdf_delay_mem #(
    .MAX_DELAY   (MAX_DELAY),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_delay_mem (
    .clk     (clk),
    .en      (item_en),
    .waddr   (waddr),
    .wdata   (sample2_r),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  // A same-slot read takes the new sample; a slot never written reads zero.
  always_comb begin
    if (rd3_r.fwd) begin
      delayed3 = sample3_r;
    end else if (rd3_r.stored) begin
      delayed3 = rdata;
    end else begin
      delayed3 = '0;
    end
  end

  sdf_mix #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mix (
    .clk     (clk),
    .en      (advance),
    .dry     (sample3_r),
    .delayed (delayed3),
    .depth   (depth3_r),
    .mix     (mix)
  );

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = sample_out_r;

endmodule

### rtl/sdf_step_gen.sv
// ----------------------------------------------------------------------------
// Sweep step generator
// Converts the Q8.8 sweep rate into the signed Q16 read position step.
// ----------------------------------------------------------------------------
module sdf_step_gen import sdf_pkg::*; (
  input  logic signed [RATE_W-1:0] sweep_rate,
  output logic signed [STEP_W-1:0] step
);

  localparam int YS_W = STEP_Y_W + 1;
  localparam int P_W  = STEP_Y_W + RECIP_W;

  logic signed [YS_W-1:0]   y_s;
  logic [STEP_Y_W-1:0]      y;
  logic [P_W-1:0]           prod;
  logic [STEP_W-1:0]        quot;
  logic signed [STEP_W:0]   step_w;

  assign y_s    = YS_W'($signed({sweep_rate, {RATE_SHIFT{1'b0}}})) + YS_W'(STEP_Y_BIAS);
  assign y      = y_s[STEP_Y_W-1:0];
  // Division by 25 as a multiply by the scaled reciprocal.
  assign prod   = P_W'(y) * P_W'(RECIP_M);
  assign quot   = prod[RECIP_SH +: STEP_W];
  assign step_w = $signed({1'b0, quot}) - (STEP_W + 1)'(STEP_OFFSET);
  assign step   = step_w[STEP_W-1:0];

endmodule

### rtl/sdf_position.sv
// ----------------------------------------------------------------------------
// Flanger position control
// Write index, written-prefix mark, fractional read position and the
// iterative reduction of the read position after a length change.
// ----------------------------------------------------------------------------
module sdf_position import sdf_pkg::*; #(
  parameter int MAX_DELAY = MAX_DELAY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_en,
  input  logic                          cfg_we,
  input  logic [$clog2(MAX_DELAY+1)-1:0] eff_len,
  input  logic signed [STEP_W-1:0]      step,
  output logic [$clog2(MAX_DELAY)-1:0]  waddr,
  output logic [$clog2(MAX_DELAY)-1:0]  raddr,
  output rd_info_t                      rd_info,
  output logic                          busy
);

  localparam int AW  = $clog2(MAX_DELAY);
  localparam int LW  = $clog2(MAX_DELAY + 1);
  localparam int PW  = AW + FRAC_W;
  localparam int LQW = LW + FRAC_W;
  localparam int SW  = LQW + 2;
  localparam int KW  = $clog2(AW);
  localparam int SHW = LQW + AW;

  norm_state_t          state_r, state_nxt;
  logic [KW-1:0]        k_r, k_nxt;
  logic [AW-1:0]        widx_r, widx_nxt;
  logic [LW-1:0]        hwm_r, hwm_nxt;
  logic [PW-1:0]        read_pos_r, read_pos_nxt;
  logic [PW-1:0]        base_r, base_nxt;

  logic [LQW-1:0]       lq;
  logic signed [SW-1:0] lq_s, pos, pos_up, pos_dn1, pos_dn2;
  logic [PW-1:0]        new_pos;
  logic [LW-1:0]        widx_inc;
  logic [SHW-1:0]       lq_sh;
  logic                 rem_ge;

  assign lq      = {eff_len, {FRAC_W{1'b0}}};
  assign lq_s    = $signed(SW'(lq));
  assign pos     = $signed(SW'(base_r)) + SW'(step);
  assign pos_up  = pos + lq_s;
  assign pos_dn1 = pos - lq_s;
  assign pos_dn2 = pos_dn1 - lq_s;

  // The base is below the length, so one wrap up or at most two down.
  always_comb begin
    if (pos[SW-1]) begin
      new_pos = pos_up[PW-1:0];
    end else if (pos_dn1[SW-1]) begin
      new_pos = pos[PW-1:0];
    end else if (pos_dn2[SW-1]) begin
      new_pos = pos_dn1[PW-1:0];
    end else begin
      new_pos = pos_dn2[PW-1:0];
    end
  end

  assign widx_inc = LW'(widx_r) + LW'(1);
  assign lq_sh    = SHW'(lq) << k_r;
  assign rem_ge   = LQW'(base_r >> k_r) >= lq;

  always_comb begin
    state_nxt    = state_r;
    k_nxt        = k_r;
    widx_nxt     = widx_r;
    hwm_nxt      = hwm_r;
    read_pos_nxt = read_pos_r;
    base_nxt     = base_r;
    case (state_r)
      NORM_IDLE: begin
        if (cfg_we) begin
          state_nxt = NORM_RUN;
          k_nxt     = KW'(AW - 1);
          base_nxt  = read_pos_r;
        end else if (item_en) begin
          widx_nxt     = (widx_inc >= eff_len) ? '0 : widx_inc[AW-1:0];
          hwm_nxt      = (widx_inc > hwm_r) ? widx_inc : hwm_r;
          read_pos_nxt = new_pos;
          base_nxt     = new_pos;
        end
      end
      NORM_RUN: begin
        if (cfg_we) begin
          k_nxt    = KW'(AW - 1);
          base_nxt = read_pos_r;
        end else begin
          if (rem_ge) begin
            base_nxt = base_r - lq_sh[PW-1:0];
          end
          if (k_r == '0) begin
            state_nxt = NORM_IDLE;
          end else begin
            k_nxt = k_r - KW'(1);
          end
        end
      end
      default: begin
        state_nxt = NORM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= NORM_IDLE;
      k_r        <= '0;
      widx_r     <= '0;
      hwm_r      <= '0;
      read_pos_r <= '0;
      base_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      k_r        <= k_nxt;
      widx_r     <= widx_nxt;
      hwm_r      <= hwm_nxt;
      read_pos_r <= read_pos_nxt;
      base_r     <= base_nxt;
    end
  end

  assign waddr          = widx_r;
  assign raddr          = read_pos_r[PW-1:FRAC_W];
  assign rd_info.fwd    = (raddr == widx_r);
  assign rd_info.stored = (LW'(raddr) < hwm_r);
  assign busy           = (state_r == NORM_RUN);

endmodule

### rtl/sdf_delay_mem.sv
// ----------------------------------------------------------------------------
// Flanger delay memory
// Single write port and one registered read port, both advancing together.
// ----------------------------------------------------------------------------
module sdf_delay_mem import sdf_pkg::*; #(
  parameter int MAX_DELAY   = MAX_DELAY_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [$clog2(MAX_DELAY)-1:0]  waddr,
  input  logic [SAMPLE_BITS-1:0]        wdata,
  input  logic [$clog2(MAX_DELAY)-1:0]  raddr,
  output logic [SAMPLE_BITS-1:0]        rdata_r
);

  logic [SAMPLE_BITS-1:0] mem [MAX_DELAY];

  // The read returns the old contents; the caller forwards a same-slot write.
  always_ff @(posedge clk) begin
    if (en) begin
      mem[waddr] <= wdata;
      rdata_r    <= mem[raddr];
    end
  end

endmodule

### rtl/sdf_mix.sv
// ----------------------------------------------------------------------------
// Flanger wet/dry mixer
// Registered depth product, then rounding, dry add and saturation.
// ----------------------------------------------------------------------------
module sdf_mix import sdf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [SAMPLE_BITS-1:0] dry,
  input  logic signed [SAMPLE_BITS-1:0] delayed,
  input  logic signed [DEPTH_W-1:0]     depth,
  output logic signed [SAMPLE_BITS-1:0] mix
);

  localparam int PRW  = SAMPLE_BITS + DEPTH_W;
  localparam int WW   = PRW - DEPTH_FRAC;
  localparam int SUMW = WW + 1;

  logic signed [PRW-1:0]         prod_r;
  logic signed [SAMPLE_BITS-1:0] dry_r;
  logic signed [PRW-1:0]         rnd;
  logic signed [WW-1:0]          wet;
  logic signed [SUMW-1:0]        sum;
  logic [SUMW-SAMPLE_BITS:0]     upper;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= delayed * depth;
      dry_r  <= dry;
    end
  end

  // Round to nearest with ties upward, then an arithmetic shift out of Q4.12.
  assign rnd   = prod_r + PRW'(ROUND_HALF);
  assign wet   = rnd[PRW-1:DEPTH_FRAC];
  assign sum   = SUMW'(dry_r) + SUMW'(wet);
  assign upper = sum[SUMW-1:SAMPLE_BITS-1];

  always_comb begin
    if ((&upper) || (~|upper)) begin
      mix = sum[SAMPLE_BITS-1:0];
    end else if (sum[SUMW-1]) begin
      mix = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
    end else begin
      mix = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    end
  end

endmodule
